@@ rtl/core/mob_pkg.sv @@
// ============================================================================
// mob_pkg
// Shared widths, the queue item, the result record and the sort engine states
// of the median-of-block unit.
// ============================================================================
package mob_pkg;

	// Port widths fixed by the interface
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int USED_W   = 7;

	// Queue between the front end and the sort engine
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// One sample as it travels from the front end to the sort engine
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} item_t;

	// One finished block result
	typedef struct packed {
		logic signed [MEDIAN_W-1:0] median;
		logic [USED_W-1:0]          used;
		logic                       overflow;
	} result_t;

	// Sort engine sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CMP,
		ST_PUT,
		ST_FIN,
		ST_MID,
		ST_MID2,
		ST_EMIT
	} back_state_t;

endpackage

@@ rtl/core/mob_ram.sv @@
// ============================================================================
// mob_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module mob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/mob_front.sv @@
// ============================================================================
// mob_front
// Input side: accepts samples, narrows them to the stored value width and
// holds them in a short queue ahead of the sort engine.
// ============================================================================
module mob_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [mob_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                last_item,
	output mob_pkg::item_t                      q_item,
	output logic                                q_valid,
	input  logic                                q_pop
);
	import mob_pkg::*;

	localparam int SHIFT = SAMPLE_W - VALUE_WIDTH;

	item_t                 fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       cnt_q;
	logic signed [SAMPLE_W-1:0] shl;
	item_t                 in_item;
	logic                  wr_en;
	logic                  rd_en;

	// Classify: keep the low value bits, sign-extended
	always_comb begin
		shl           = sample_value <<< SHIFT;
		in_item.value = shl >>> SHIFT;
		in_item.last  = last_item;
	end

	assign full    = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;

	// Store an accepted transaction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

@@ rtl/core/mob_back.sv @@
// ============================================================================
// mob_back
// Sort engine: insertion-sorts each sample into the store RAM, reads the
// middle entries at the end of a block and holds the result for the reader.
// ============================================================================
module mob_back #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mob_pkg::item_t   q_item,
	input  logic             q_valid,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output mob_pkg::result_t result
);
	import mob_pkg::*;

	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int EXT = MEDIAN_W - VALUE_WIDTH;

	back_state_t                 state_q;
	back_state_t                 state_d;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                        last_q;
	logic [CW-1:0]               pos_q;
	logic [CW-1:0]               cnt_q;
	logic                        drop_q;
	logic signed [VALUE_WIDTH-1:0] lo_q;
	logic signed [MEDIAN_W-1:0]  med_q;
	logic                        out_valid_q;
	result_t                     out_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [VALUE_WIDTH-1:0]      ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [VALUE_WIDTH-1:0]      ram_rdata;
	logic signed [VALUE_WIDTH-1:0] rd_s;

	logic                        full_store;
	logic                        shift_up;
	logic [CW-1:0]               half;
	logic [CW-1:0]               pos_dec;
	logic                        ins_done;
	logic                        pos_ld;
	logic [CW-1:0]               pos_val;
	logic                        drop_set;
	logic                        lo_ld;
	logic                        med_ld;
	logic signed [MEDIAN_W-1:0]  med_val;
	logic                        emit;

	function automatic logic signed [MEDIAN_W-1:0] sext(input logic [VALUE_WIDTH-1:0] x);
		return {{EXT{x[VALUE_WIDTH-1]}}, x};
	endfunction

	mob_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_s       = ram_rdata;
	assign full_store = (cnt_q == CW'(CAPACITY));
	assign shift_up   = (rd_s > val_q);
	assign half       = cnt_q >> 1;
	assign pos_dec    = pos_q - CW'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (full_store || cnt_q == '0) begin
					state_d = last_q ? ST_FIN : ST_IDLE;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (shift_up) begin
					state_d = (pos_dec == '0) ? ST_PUT : ST_CMP;
				end else begin
					state_d = last_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_PUT:  state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN:  state_d = ST_MID;
			ST_MID:  state_d = cnt_q[0] ? ST_EMIT : ST_MID2;
			ST_MID2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || pop) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = val_q;
		ram_raddr = pos_q[AW-1:0];
		ins_done  = 1'b0;
		pos_ld    = 1'b0;
		pos_val   = pos_q;
		drop_set  = 1'b0;
		lo_ld     = 1'b0;
		med_ld    = 1'b0;
		med_val   = sext(rd_s) <<< 1;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_START: begin
				// Drop when full, write straight in when empty, else start the scan
				if (full_store) begin
					drop_set = 1'b1;
				end else if (cnt_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ins_done  = 1'b1;
				end else begin
					pos_ld    = 1'b1;
					pos_val   = cnt_q;
					ram_raddr = AW'(cnt_q - CW'(1));
				end
			end
			ST_CMP: begin
				// Move the larger neighbor up, or drop the new value in place
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = rd_s;
					pos_ld    = 1'b1;
					pos_val   = pos_dec;
					ram_raddr = AW'(pos_dec - CW'(1));
				end else begin
					ins_done = 1'b1;
				end
			end
			ST_PUT: begin
				ram_we   = 1'b1;
				ins_done = 1'b1;
			end
			ST_FIN: begin
				ram_raddr = half[AW-1:0];
			end
			ST_MID: begin
				if (cnt_q[0]) begin
					med_ld = 1'b1;
				end else begin
					lo_ld     = 1'b1;
					ram_raddr = AW'(half - CW'(1));
				end
			end
			ST_MID2: begin
				med_ld  = 1'b1;
				med_val = sext(lo_q) + sext(rd_s);
			end
			ST_EMIT: begin
				emit = !out_valid_q || pop;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Sequencer and block control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_done) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (drop_set) begin
				drop_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				drop_q      <= 1'b0;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			val_q  <= q_item.value[VALUE_WIDTH-1:0];
			last_q <= q_item.last;
		end
		if (pos_ld) begin
			pos_q <= pos_val;
		end
		if (lo_ld) begin
			lo_q <= rd_s;
		end
		if (med_ld) begin
			med_q <= med_val;
		end
		if (emit) begin
			out_q.median   <= med_q;
			out_q.used     <= USED_W'(cnt_q);
			out_q.overflow <= drop_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ rtl/core/median_of_block_top.sv @@
// ============================================================================
// median_of_block_top
// Median of a block of signed samples, returned as twice the median.
// ============================================================================
// Usage:
//   Input queue: drive sample_value and last_item with push; a transaction
//   goes in on a clock edge with push high and full low. last_item closes a
//   block. Up to four samples wait in the front queue.
//   Result queue: while empty is low, median_doubled (one fractional bit),
//   items_used and overflow show the result; pop takes it.
//   Samples past CAPACITY are dropped and set overflow on that block.
//   Each sample is inserted by a scan over the stored entries that it passes
//   in the store RAM, which has a single read port; the scan is skipped when
//   the store is empty or full.
//   Closing a block reads the middle entry, or both middle entries for an
//   even count, before the result register is loaded.
//   A stalled result holds in its register; the engine keeps sorting the next
//   block and waits only when a second result is ready.
//   Reset (arst_n low) empties both queues and clears the count and overflow
//   flag; the store needs no clearing.
// ============================================================================
module median_of_block_top #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [mob_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                last_item,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [mob_pkg::MEDIAN_W-1:0] median_doubled,
	output logic [mob_pkg::USED_W-1:0]          items_used,
	output logic                                overflow
);
	import mob_pkg::*;

	item_t   q_item;
	logic    q_valid;
	logic    q_pop;
	result_t result;

	mob_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.last_item    (last_item),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_pop        (q_pop)
	);

	mob_back #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	assign median_doubled = result.median;
	assign items_used     = result.used;
	assign overflow       = result.overflow;

endmodule

@@ rtl/core/mob_checker.sv @@
// ============================================================================
// mob_checker
// Port-level checks on the median-of-block result queue.
// ============================================================================
module mob_checker #(
	parameter int CAPACITY = 64
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                empty,
	input logic                                pop,
	input logic signed [mob_pkg::MEDIAN_W-1:0] median_doubled,
	input logic [mob_pkg::USED_W-1:0]          items_used,
	input logic                                overflow
);
	import mob_pkg::*;

	localparam logic [USED_W-1:0] CAP_USED = USED_W'(CAPACITY);

	// A stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(median_doubled) && $stable(items_used)))
		else $error("result changed while stalled");

	// Dropping only happens with a full store
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && overflow) |-> (items_used == CAP_USED))
		else $error("overflow without a full store");

	// A result always covers at least one sample; checked only while CAPACITY is below 128
	a_used_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && CAPACITY < 128) |-> (items_used != '0))
		else $error("result with no samples");

	// An odd count gives a whole median
	a_odd_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && items_used[0]) |-> !median_doubled[0])
		else $error("fraction on an odd-count median");

endmodule

bind median_of_block_top mob_checker #(
	.CAPACITY (CAPACITY)
) u_mob_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.median_doubled (median_doubled),
	.items_used     (items_used),
	.overflow       (overflow)
);
